// File: rtl/core/circuit_breaker_controller_assert.svh
// Assertion macros for the circuit breaker controller checker.
// No dependencies.
`ifndef CIRCUIT_BREAKER_CONTROLLER_ASSERT_SVH
`define CIRCUIT_BREAKER_CONTROLLER_ASSERT_SVH
`define CB_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: check failed");
`define CB_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: check failed");
`endif

// File: rtl/core/cbc_pkg.sv
// Shared types and constants for the circuit breaker controller.
// No dependencies.
package cbc_pkg;
  localparam logic [1:0] ST_CLOSED = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_HALF   = 2'd2;
  localparam logic [1:0] OUT_OK    = 2'd0;
  localparam logic [1:0] OUT_FAIL  = 2'd1;
  localparam logic [2:0] REG_CONSEC = 3'd0;
  localparam logic [2:0] REG_WINDOW = 3'd1;
  localparam logic [2:0] REG_MINREQ = 3'd2;
  localparam logic [2:0] REG_FPCT   = 3'd3;
  localparam logic [2:0] REG_SPCT   = 3'd4;
  localparam logic [2:0] REG_BASE   = 3'd5;
  localparam logic [2:0] REG_CAP    = 3'd6;
  localparam logic [2:0] REG_PROBE  = 3'd7;

  // bucket count, a power of two so the bucket width and slot are shifts and masks
  localparam int NUM_BUCKETS = 16;
  localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);

  // divider request/response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;
  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;
endpackage

// File: rtl/core/cbc_divider.sv
// Shared restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on cbc_pkg.
module cbc_divider import cbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [63:0] quot;
  logic [32:0] rem;
  logic [31:0] den;
  logic [6:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem[31:0], quot[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quot <= req.num;
        den <= req.den;
        rem <= '0;
        count <= 7'd64;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quot[63]};
          quot <= {quot[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done, quot};
endmodule

// File: rtl/core/circuit_breaker_controller.sv
// Circuit breaker controller: closed, open and half-open states with a
// bucketed sliding window of requests, failures and slow results.
//
// Usage: an input transaction carries mode (request or record), outcome,
// slow_flag, turn_tag and now_ms over valid/ready. Each transaction gives
// exactly one result transaction with the grant, turn number, state,
// can_try, window statistics and current open length.
// Requests, half-open records and ignored records pass S_DISP and then
// S_OUT, which registers out_valid. A closed-state ok or fail record
// also passes S_DT, S_DK, S_ADD, S_SUM, S_FIN, S_DF, S_DS and S_DEC: one
// shared 64/32 bit serial divider computes the tick, the kept tick count
// and both percentages in turn, and the bucket sum walks the NUM_BUCKETS
// entries one a cycle. The bucket width is a shift of the window length.
// One transaction at a time: in_ready is low while busy and rises the
// cycle after the result is taken.
// Reset: all state returns to closed, buckets empty, registers to their
// reset values. The configuration port writes at any cycle.
// Stall: the result holds in its register until out_ready; a new input
// transaction is taken once the result is gone.
module circuit_breaker_controller import cbc_pkg::*; #(
  parameter int PROBE_SUCCESS_NEED = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [1:0]  outcome,
  input  logic        slow_flag,
  input  logic [31:0] turn_tag,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        allowed,
  output logic [31:0] turn_out,
  output logic [1:0]  breaker_state,
  output logic        can_try,
  output logic [19:0] window_requests,
  output logic [6:0]  fail_pct,
  output logic [6:0]  slow_pct,
  output logic [31:0] open_len_ms,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int BW = BUCKET_BITS;
  localparam logic [7:0] NEED8 = (PROBE_SUCCESS_NEED < 1) ? 8'd1 : 8'(PROBE_SUCCESS_NEED);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DT    = 4'd3;
  localparam logic [3:0] S_DK    = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_DF    = 4'd7;
  localparam logic [3:0] S_DS    = 4'd8;
  localparam logic [3:0] S_DEC   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_WAIT  = 4'd12;

  logic [3:0] state;
  logic [15:0] r_consec;
  logic [31:0] r_window, r_base, r_cap;
  logic [19:0] r_minreq;
  logic [6:0]  r_fpct, r_spct;
  logic [7:0]  r_probe;

  logic [1:0]  mstate;
  logic [31:0] turn_count, open_duration, opened_time;
  logic [7:0]  probes_pending, probes_ok;
  logic [15:0] fail_streak;
  logic [NUM_BUCKETS-1:0] bvalid;
  logic [31:0] btick [NUM_BUCKETS];
  logic [15:0] breq [NUM_BUCKETS];
  logic [15:0] bfail [NUM_BUCKETS];
  logic [15:0] bslow [NUM_BUCKETS];

  logic        i_mode, i_slow;
  logic [1:0]  i_outcome;
  logic [31:0] i_tag, i_now;
  logic [31:0] tick, keep;
  logic [BW-1:0] idx;
  logic [35:0] sr, sf, ss;
  logic [6:0]  fp, sp;
  logic        div_phase;

  div_req_t dreq;
  div_rsp_t drsp;
  cbc_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // effective registers
  logic [31:0] e_window, e_base, e_cap;
  logic [7:0]  e_probe, e_need;
  logic [15:0] e_consec;
  logic [19:0] e_minreq;
  logic [6:0]  e_fpct, e_spct;
  always_comb begin
    e_window = (r_window == '0) ? 32'd1 : r_window;
    e_base   = (r_base == '0) ? 32'd1 : r_base;
    e_cap    = (r_cap > e_base) ? r_cap : e_base;
    e_probe  = (r_probe == '0) ? 8'd1 : r_probe;
    e_need   = (NEED8 < e_probe) ? NEED8 : e_probe;
    e_consec = (r_consec == '0) ? 16'd1 : r_consec;
    e_minreq = (r_minreq == '0) ? 20'd1 : r_minreq;
    e_fpct   = (r_fpct > 7'd100) ? 7'd100 : r_fpct;
    e_spct   = (r_spct > 7'd100) ? 7'd100 : r_spct;
  end

  // bucket width: window length over the bucket count, at least 1
  logic [31:0] width;
  assign width = (e_window[31:BW] == '0) ? 32'd1 : {{BW{1'b0}}, e_window[31:BW]};

  logic [31:0] elapsed;
  logic        open_el, tag_ok;
  assign elapsed = i_now - opened_time;
  assign open_el = elapsed >= open_duration;
  assign tag_ok  = (i_tag == '0) || (i_tag == turn_count);

  // bucket slot: low bits of the tick
  logic [BW-1:0] slot_c;
  assign slot_c = tick[BW-1:0];

  logic [31:0] dt;
  logic        in_win;
  assign dt = tick - btick[idx];
  assign in_win = bvalid[idx] && !(tick < btick[idx]) && (dt < keep);

  logic [32:0] dbl;
  assign dbl = {open_duration, 1'b0};

  logic rate_open;
  assign rate_open = (sr >= {16'd0, e_minreq}) &&
    ((e_fpct != '0 && fp >= e_fpct) || (e_spct != '0 && sp >= e_spct));

  assign in_ready = (state == S_IDLE);

  always_comb begin
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = 32'd1;
    if (!div_phase) begin
      unique case (state)
        S_DT: begin dreq.start = 1'b1; dreq.num = {32'd0, i_now}; dreq.den = width; end
        S_DK: begin
          dreq.start = 1'b1;
          dreq.num = {32'd0, e_window} + {32'd0, width} - 64'd1;
          dreq.den = width;
        end
        S_DF: begin dreq.start = 1'b1; dreq.num = {28'd0, sf} * 64'd100; dreq.den = sr[31:0]; end
        S_DS: begin dreq.start = 1'b1; dreq.num = {28'd0, ss} * 64'd100; dreq.den = sr[31:0]; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_phase <= 1'b0;
      r_consec <= 16'd5; r_window <= 32'd10000; r_minreq <= 20'd20;
      r_fpct <= 7'd50; r_spct <= 7'd0; r_base <= 32'd1000;
      r_cap <= 32'd60000; r_probe <= 8'd1;
      mstate <= ST_CLOSED;
      turn_count <= '0;
      open_duration <= 32'd1000;
      opened_time <= '0;
      probes_pending <= '0;
      probes_ok <= '0;
      fail_streak <= '0;
      bvalid <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CONSEC: r_consec <= cfg_data[15:0];
          REG_WINDOW: r_window <= cfg_data;
          REG_MINREQ: r_minreq <= cfg_data[19:0];
          REG_FPCT:   r_fpct <= cfg_data[6:0];
          REG_SPCT:   r_spct <= cfg_data[6:0];
          REG_BASE:   r_base <= cfg_data;
          REG_CAP:    r_cap <= cfg_data;
          REG_PROBE:  r_probe <= cfg_data[7:0];
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            i_mode <= mode; i_outcome <= outcome; i_slow <= slow_flag;
            i_tag <= turn_tag; i_now <= now_ms;
            allowed <= 1'b0; window_requests <= '0; fail_pct <= '0; slow_pct <= '0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          state <= S_OUT;
          if (!i_mode) begin
            if (mstate == ST_CLOSED) allowed <= 1'b1;
            else if (mstate == ST_OPEN) begin
              if (open_el) begin
                mstate <= ST_HALF; turn_count <= turn_count + 32'd1;
                probes_pending <= 8'd1; probes_ok <= '0; allowed <= 1'b1;
              end
            end else if (probes_pending < e_probe) begin
              probes_pending <= probes_pending + 8'd1; allowed <= 1'b1;
            end
          end else if (tag_ok && mstate != ST_OPEN) begin
            if (mstate == ST_HALF) begin
              if (i_outcome == OUT_FAIL) begin
                open_duration <= (dbl < {1'b0, e_cap}) ? dbl[31:0] : e_cap;
                mstate <= ST_OPEN; turn_count <= turn_count + 32'd1;
                opened_time <= i_now; probes_pending <= '0; probes_ok <= '0;
              end else if (i_outcome == OUT_OK &&
                           (probes_ok == 8'hFF || probes_ok + 8'd1 >= e_need)) begin
                mstate <= ST_CLOSED; turn_count <= turn_count + 32'd1;
                fail_streak <= '0; probes_pending <= '0; probes_ok <= '0;
                open_duration <= e_base; bvalid <= '0;
              end else begin
                // skip or a success short of the close count: release the probe
                if (probes_pending != '0) probes_pending <= probes_pending - 8'd1;
                if (i_outcome == OUT_OK) probes_ok <= probes_ok + 8'd1;
              end
            end else if (i_outcome == OUT_OK || i_outcome == OUT_FAIL) begin
              if (i_outcome == OUT_FAIL) begin
                if (fail_streak != 16'hFFFF) fail_streak <= fail_streak + 16'd1;
              end else fail_streak <= '0;
              state <= S_DT;
            end
          end
        end
        S_DT, S_DK, S_DF, S_DS: begin
          if (!div_phase) div_phase <= 1'b1;
          else if (drsp.done) begin
            div_phase <= 1'b0;
            unique case (state)
              S_DT: begin tick <= drsp.quot[31:0]; state <= S_DK; end
              S_DK: begin keep <= drsp.quot[31:0]; state <= S_ADD; end
              S_DF: begin fp <= drsp.quot[6:0]; state <= S_DS; end
              default: begin sp <= drsp.quot[6:0]; state <= S_DEC; end
            endcase
          end
        end
        S_ADD: begin
          // reclaim the slot when stale, then count this transaction
          if (!bvalid[slot_c] || btick[slot_c] != tick) begin
            bvalid[slot_c] <= 1'b1;
            btick[slot_c] <= tick;
            breq[slot_c] <= 16'd1;
            bfail[slot_c] <= {15'd0, i_outcome == OUT_FAIL};
            bslow[slot_c] <= {15'd0, i_slow};
          end else begin
            if (breq[slot_c] != 16'hFFFF) breq[slot_c] <= breq[slot_c] + 16'd1;
            if (i_outcome == OUT_FAIL && bfail[slot_c] != 16'hFFFF)
              bfail[slot_c] <= bfail[slot_c] + 16'd1;
            if (i_slow && bslow[slot_c] != 16'hFFFF) bslow[slot_c] <= bslow[slot_c] + 16'd1;
          end
          idx <= '0; sr <= '0; sf <= '0; ss <= '0; fp <= '0; sp <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          if (in_win) begin
            sr <= sr + 36'(breq[idx]); sf <= sf + 36'(bfail[idx]); ss <= ss + 36'(bslow[idx]);
          end
          if (idx == BW'(NUM_BUCKETS - 1)) state <= S_FIN;
          else idx <= idx + BW'(1);
        end
        S_FIN: state <= (sr != '0) ? S_DF : S_DEC;
        S_DEC: begin
          window_requests <= (sr > 36'hFFFFF) ? 20'hFFFFF : sr[19:0];
          fail_pct <= fp; slow_pct <= sp;
          if (fail_streak >= e_consec || rate_open) begin
            open_duration <= e_base;
            if (mstate != ST_OPEN) turn_count <= turn_count + 32'd1;
            mstate <= ST_OPEN; opened_time <= i_now;
            probes_pending <= '0; probes_ok <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          turn_out <= turn_count;
          breaker_state <= mstate;
          open_len_ms <= open_duration;
          unique case (mstate)
            ST_CLOSED: can_try <= 1'b1;
            ST_HALF:   can_try <= probes_pending < e_probe;
            default:   can_try <= open_el;
          endcase
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/cbc_checker.sv
// Port-level checker for the circuit breaker controller, with its bind.
// Depends on cbc_pkg and circuit_breaker_controller_assert.svh.
`include "circuit_breaker_controller_assert.svh"
module cbc_checker import cbc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  breaker_state,
  input logic        allowed,
  input logic        can_try
);
  // one transaction in flight: no input accepted while a result waits
  `CB_ASSERT_IMPL(no_overlap, clk, rst, out_valid, !in_ready)
  `CB_ASSERT_NEXT(busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `CB_ASSERT_IMPL(state_legal, clk, rst, out_valid, breaker_state <= ST_HALF)
  `CB_ASSERT_IMPL(closed_try, clk, rst, out_valid && breaker_state == ST_CLOSED, can_try)
  `CB_ASSERT_NEXT(hold_result, clk, rst, out_valid && !out_ready,
                  out_valid && $stable(allowed) && $stable(breaker_state))
endmodule

bind circuit_breaker_controller cbc_checker u_cbc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .breaker_state(breaker_state),
  .allowed(allowed), .can_try(can_try)
);

// File: tb/tb_circuit_breaker_controller.sv
// Self-checking testbench for circuit_breaker_controller: directed and random
// transactions, checked against a behavioral breaker model kept in this file.
// Depends on cbc_pkg and the circuit_breaker_controller RTL.
`timescale 1ns / 100ps

module tb_circuit_breaker_controller;
  import cbc_pkg::*;

  localparam int NB = 16;
  localparam logic [1:0] OUT_SKIP = 2'd2;
  localparam logic [1:0] OUT_BAD = 2'd3;
  localparam logic MODE_REQ = 1'b0;
  localparam logic MODE_REC = 1'b1;

  typedef enum int {TAG_ZERO, TAG_CUR, TAG_STALE, TAG_RAND} tag_kind_e;

  typedef struct {
    logic        mode;
    logic [1:0]  outcome;
    logic        slow;
    tag_kind_e   kind;
    logic [31:0] tag;
    logic [31:0] now;
  } call_t;

  typedef struct {
    logic        allowed;
    logic [31:0] turn;
    logic [1:0]  state;
    logic        can_try;
    logic [19:0] wreq;
    logic [6:0]  fpct;
    logic [6:0]  spct;
    logic [31:0] open_len;
  } verdict_t;

  logic clk, rst;
  logic in_valid, in_ready, mode, slow_flag;
  logic [1:0] outcome;
  logic [31:0] turn_tag, now_ms;
  logic out_valid, out_ready, allowed, can_try;
  logic [31:0] turn_out, open_len_ms;
  logic [1:0] breaker_state;
  logic [19:0] window_requests;
  logic [6:0] fail_pct, slow_pct;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  circuit_breaker_controller i_dut (.*);

  call_t    pending_calls[$];
  verdict_t expected_verdicts[$];
  int       send_idle_pct, recv_stall_pct;
  bit       failed;
  logic [31:0] t_ms;

  // breaker model: registers as written, and state
  logic [31:0] r_consec, r_window, r_minreq, r_fpct, r_spct, r_base, r_cap, r_probe;
  logic [1:0]  m_state;
  logic [31:0] m_turn, m_open_dur, m_opened, m_pending, m_ok, m_streak;
  logic        bkt_used[NB];
  logic [31:0] bkt_tick[NB];
  logic [15:0] bkt_req[NB], bkt_fail[NB], bkt_slow[NB];

  function automatic logic [31:0] at_least1(logic [31:0] v);
    return (v == 0) ? 32'd1 : v;
  endfunction

  function automatic logic [31:0] pct_clip(logic [31:0] v);
    return (v > 100) ? 32'd100 : v;
  endfunction

  function automatic logic [31:0] base_len();
    return at_least1(r_base);
  endfunction

  function automatic logic [31:0] bucket_span();
    logic [31:0] w;
    w = at_least1(r_window) / NB;
    return (w == 0) ? 32'd1 : w;
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit open_done(logic [31:0] now);
    return (now - m_opened) >= m_open_dur;
  endfunction

  task automatic change_state(input logic [1:0] to);
    if (m_state != to) begin
      m_state = to;
      m_turn = m_turn + 1;
    end
  endtask

  task automatic trip_open(input bit doubled, input logic [31:0] now);
    logic [63:0] nx, cap;
    if (doubled) begin
      cap = (r_cap > base_len()) ? r_cap : base_len();
      nx = 64'(m_open_dur) * 2;
      m_open_dur = (nx < cap) ? nx[31:0] : cap[31:0];
    end else begin
      m_open_dur = base_len();
    end
    change_state(ST_OPEN);
    m_opened = now;
    m_pending = 0;
    m_ok = 0;
  endtask

  task automatic reclose();
    change_state(ST_CLOSED);
    m_streak = 0;
    m_pending = 0;
    m_ok = 0;
    m_open_dur = base_len();
    for (int i = 0; i < NB; i++) begin
      bkt_used[i] = 0;
      bkt_tick[i] = 0;
      bkt_req[i] = 0;
      bkt_fail[i] = 0;
      bkt_slow[i] = 0;
    end
  endtask

  task automatic breaker_step(input call_t c, output verdict_t v);
    logic [31:0] width, tick, slot, need;
    logic [63:0] keep, sr, sf, ss;
    bit skip, fail, rate_trip;
    v = '{default: '0};
    if (c.mode == MODE_REQ) begin
      if (m_state == ST_CLOSED) begin
        v.allowed = 1;
      end else if (m_state == ST_HALF || open_done(c.now)) begin
        if (m_state == ST_OPEN) begin
          change_state(ST_HALF);
          m_pending = 0;
          m_ok = 0;
        end
        if (m_pending < at_least1(r_probe)) begin
          m_pending++;
          v.allowed = 1;
        end
      end
    end else if ((c.tag == 0 || c.tag == m_turn) && m_state != ST_OPEN) begin
      skip = (c.outcome == OUT_SKIP || c.outcome == OUT_BAD);
      fail = (c.outcome == OUT_FAIL);
      if (m_state == ST_HALF) begin
        if (m_pending > 0) m_pending--;
        if (!skip) begin
          if (fail) begin
            trip_open(1, c.now);
          end else begin
            if (m_ok < 255) m_ok++;
            need = (at_least1(r_probe) < 1) ? at_least1(r_probe) : 32'd1;
            if (m_ok >= need) reclose();
          end
        end
      end else if (!skip) begin
        if (fail) begin
          if (m_streak < 16'hFFFF) m_streak++;
        end else begin
          m_streak = 0;
        end
        width = bucket_span();
        tick = c.now / width;
        slot = tick % NB;
        if (!bkt_used[slot] || bkt_tick[slot] != tick) begin
          bkt_used[slot] = 1;
          bkt_tick[slot] = tick;
          bkt_req[slot] = 0;
          bkt_fail[slot] = 0;
          bkt_slow[slot] = 0;
        end
        bkt_req[slot] = sat16(bkt_req[slot]);
        if (fail) bkt_fail[slot] = sat16(bkt_fail[slot]);
        if (c.slow) bkt_slow[slot] = sat16(bkt_slow[slot]);
        keep = (64'(at_least1(r_window)) + width - 1) / width;
        sr = 0;
        sf = 0;
        ss = 0;
        for (int i = 0; i < NB; i++) begin
          if (bkt_used[i] && tick >= bkt_tick[i] && 64'(tick - bkt_tick[i]) < keep) begin
            sr += bkt_req[i];
            sf += bkt_fail[i];
            ss += bkt_slow[i];
          end
        end
        if (sr != 0) begin
          v.fpct = 7'(sf * 100 / sr);
          v.spct = 7'(ss * 100 / sr);
        end
        v.wreq = (sr > 64'hFFFFF) ? 20'hFFFFF : sr[19:0];
        rate_trip = sr >= at_least1(r_minreq) &&
          ((pct_clip(r_fpct) > 0 && v.fpct >= pct_clip(r_fpct)) ||
           (pct_clip(r_spct) > 0 && v.spct >= pct_clip(r_spct)));
        if (m_streak >= at_least1(r_consec) || rate_trip) trip_open(0, c.now);
      end
    end
    v.turn = m_turn;
    v.state = m_state;
    v.open_len = m_open_dur;
    if (m_state == ST_CLOSED) v.can_try = 1;
    else if (m_state == ST_HALF) v.can_try = m_pending < at_least1(r_probe);
    else v.can_try = open_done(c.now);
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("circuit_breaker_controller regression: fail");
    $finish;
  end

  // driver: hold the payload until taken, resolve the turn tag at load time
  bit took;
  always @(posedge clk) begin
    verdict_t v;
    call_t c;
    took = 0;
    if (!rst && in_valid && in_ready) begin
      c.mode = mode;
      c.outcome = outcome;
      c.slow = slow_flag;
      c.tag = turn_tag;
      c.now = now_ms;
      breaker_step(c, v);
      expected_verdicts.push_back(v);
      took = 1;
    end
  end

  always @(negedge clk) begin
    call_t c;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst || (in_valid && !took)) begin
      // hold
    end else if (pending_calls.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      c = pending_calls.pop_front();
      case (c.kind)
        TAG_ZERO:  turn_tag <= 32'd0;
        TAG_CUR:   turn_tag <= m_turn;
        TAG_STALE: turn_tag <= m_turn - 1;
        default:   turn_tag <= c.tag;
      endcase
      mode <= c.mode;
      outcome <= c.outcome;
      slow_flag <= c.slow;
      now_ms <= c.now;
      in_valid <= 1;
    end else begin
      in_valid <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result turn %0d state %0d", $time, turn_out, breaker_state);
        failed = 1;
      end else begin
        e = expected_verdicts.pop_front();
        if (allowed !== e.allowed || turn_out !== e.turn || breaker_state !== e.state ||
            can_try !== e.can_try || window_requests !== e.wreq || fail_pct !== e.fpct ||
            slow_pct !== e.spct || open_len_ms !== e.open_len) begin
          $display("%0t: expected allowed %0d turn %0d state %0d can_try %0d req %0d fpct %0d spct %0d open %0d",
                   $time, e.allowed, e.turn, e.state, e.can_try, e.wreq, e.fpct, e.spct,
                   e.open_len);
          $display("%0t: actual   allowed %0d turn %0d state %0d can_try %0d req %0d fpct %0d spct %0d open %0d",
                   $time, allowed, turn_out, breaker_state, can_try, window_requests,
                   fail_pct, slow_pct, open_len_ms);
          failed = 1;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CONSEC: r_consec = val & 32'hFFFF;
      REG_WINDOW: r_window = val;
      REG_MINREQ: r_minreq = val & 32'hFFFFF;
      REG_FPCT:   r_fpct = val & 32'h7F;
      REG_SPCT:   r_spct = val & 32'h7F;
      REG_BASE:   r_base = val;
      REG_CAP:    r_cap = val;
      default:    r_probe = val & 32'hFF;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic queue_call(input logic m, input logic [1:0] oc, input logic s,
                            input tag_kind_e k, input logic [31:0] now);
    call_t c;
    c.mode = m;
    c.outcome = oc;
    c.slow = s;
    c.kind = k;
    c.tag = {$urandom};
    c.now = now;
    pending_calls.push_back(c);
  endtask

  task automatic drain();
    while (pending_calls.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] big;
    int pick;
    rst = 1;
    in_valid = 0;
    mode = 0;
    outcome = 0;
    slow_flag = 0;
    turn_tag = 0;
    now_ms = 0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    failed = 0;
    r_consec = 5; r_window = 10000; r_minreq = 20; r_fpct = 50; r_spct = 0;
    r_base = 1000; r_cap = 60000; r_probe = 1;
    m_state = ST_CLOSED;
    m_turn = 0;
    m_opened = 0;
    reclose();
    m_turn = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset settings, through every state and back
    queue_call(MODE_REQ, OUT_OK, 0, TAG_ZERO, 32'd0);
    queue_call(MODE_REC, OUT_OK, 1, TAG_ZERO, 32'd0);
    queue_call(MODE_REC, OUT_BAD, 1, TAG_CUR, 32'd5);
    queue_call(MODE_REC, OUT_SKIP, 0, TAG_CUR, 32'd6);
    queue_call(MODE_REC, OUT_FAIL, 0, TAG_RAND, 32'd7);
    for (int i = 0; i < 5; i++) queue_call(MODE_REC, OUT_FAIL, i[0], TAG_CUR, 32'd10 + i);
    queue_call(MODE_REC, OUT_OK, 0, TAG_ZERO, 32'd20);
    queue_call(MODE_REQ, OUT_OK, 0, TAG_ZERO, 32'd500);
    queue_call(MODE_REQ, OUT_OK, 0, TAG_ZERO, 32'd1014);
    queue_call(MODE_REQ, OUT_OK, 0, TAG_ZERO, 32'd1015);
    queue_call(MODE_REC, OUT_OK, 0, TAG_STALE, 32'd1016);
    queue_call(MODE_REC, OUT_FAIL, 0, TAG_CUR, 32'd1017);
    queue_call(MODE_REQ, OUT_OK, 0, TAG_ZERO, 32'd3017);
    queue_call(MODE_REC, OUT_SKIP, 1, TAG_CUR, 32'd3018);
    queue_call(MODE_REC, OUT_OK, 0, TAG_CUR, 32'd3019);
    queue_call(MODE_REC, OUT_FAIL, 1, TAG_ZERO, 32'hFFFF_FFFF);
    queue_call(MODE_REC, OUT_OK, 1, TAG_ZERO, 32'd3);
    queue_call(MODE_REQ, OUT_BAD, 1, TAG_RAND, 32'hFFFF_FFFF);
    drain();

    t_ms = 0;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // settings: small windows mostly, extremes in a few phases
      case (ph)
        3: begin
          write_reg(REG_CONSEC, 32'd65535); write_reg(REG_WINDOW, 32'hFFFF_FFFF);
          write_reg(REG_MINREQ, 32'd1);     write_reg(REG_FPCT, 32'd100);
          write_reg(REG_SPCT, 32'd100);     write_reg(REG_BASE, 32'hFFFF_FFFF);
          write_reg(REG_CAP, 32'd1);        write_reg(REG_PROBE, 32'd255);
          t_ms = {$urandom};
        end
        6: begin
          write_reg(REG_CONSEC, 32'd1);     write_reg(REG_WINDOW, 32'd1);
          write_reg(REG_MINREQ, 32'hFFFFF); write_reg(REG_FPCT, 32'd0);
          write_reg(REG_SPCT, 32'd0);       write_reg(REG_BASE, 32'd1);
          write_reg(REG_CAP, 32'hFFFF_FFFF); write_reg(REG_PROBE, 32'd1);
          t_ms = 32'hFFFF_FF00;
        end
        default: begin
          write_reg(REG_CONSEC, $urandom_range(2, 8));
          write_reg(REG_WINDOW, $urandom_range(16, 400));
          write_reg(REG_MINREQ, $urandom_range(1, 8));
          write_reg(REG_FPCT, $urandom_range(0, 100));
          write_reg(REG_SPCT, $urandom_range(0, 100));
          write_reg(REG_BASE, $urandom_range(1, 60));
          write_reg(REG_CAP, $urandom_range(1, 500));
          write_reg(REG_PROBE, $urandom_range(1, 3));
          if (ph == 8) t_ms = 32'hFFFF_FE00;
        end
      endcase
      for (int n = 0; n < 70; n++) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          big = (ph == 3) ? {$urandom} : $urandom_range(0, 1200);
          t_ms = t_ms + big;
        end else begin
          t_ms = t_ms + $urandom_range(0, 12);
        end
        if ($urandom_range(99) < 30) begin
          queue_call(MODE_REQ, 2'($urandom), 1'($urandom), TAG_RAND, t_ms);
        end else begin
          pick = $urandom_range(99);
          queue_call(MODE_REC,
                     (pick < 45) ? OUT_FAIL : (pick < 80) ? OUT_OK :
                     (pick < 92) ? OUT_SKIP : OUT_BAD,
                     1'($urandom),
                     tag_kind_e'(($urandom_range(99) < 50) ? TAG_CUR :
                                 ($urandom_range(99) < 60) ? TAG_ZERO :
                                 ($urandom_range(99) < 50) ? TAG_STALE : TAG_RAND),
                     t_ms);
        end
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (!failed && expected_verdicts.size() == 0)
      $display("circuit_breaker_controller regression: pass");
    else
      $display("circuit_breaker_controller regression: fail");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cbc_pkg.sv
rtl/core/cbc_divider.sv
rtl/core/circuit_breaker_controller.sv
rtl/core/cbc_checker.sv
tb/tb_circuit_breaker_controller.sv
